FILE: rtl/ara_pkg.sv
// ---------------------------------------------------------------------------
// Aligned range allocator package
// Shared types, constants and helper functions of the range allocator.
// ---------------------------------------------------------------------------
package ara_pkg;

   localparam int MAX_RANGES     = 64;
   localparam int PAGE_BITS      = 36;
   localparam int COUNT_BITS     = PAGE_BITS + 1;
   localparam int WIDE_BITS      = PAGE_BITS + 2;
   localparam int ORDER_BITS     = 6;
   localparam int TREE_LEVELS    = $clog2(MAX_RANGES);
   localparam int TREE_LEAVES    = 1 << TREE_LEVELS;
   localparam int USED_BITS      = $clog2(MAX_RANGES + 1);
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [WIDE_BITS-1:0] PAGE_SPACE = WIDE_BITS'(1) << PAGE_BITS;

   localparam logic [1:0] CMD_RESERVE  = 2'd0;
   localparam logic [1:0] CMD_ALLOCATE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_BASE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_COUNT = 1'd1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_BAD     = 3'd2,
      ST_FULL    = 3'd3,
      ST_MISS    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [PAGE_BITS-1:0]  request_page;
      logic [COUNT_BITS-1:0] span_pages;
      logic [ORDER_BITS-1:0] align_order;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [PAGE_BITS-1:0]  base_page;
      logic [COUNT_BITS-1:0] found_pages;
      logic                  found_kind;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0]  base;
      logic [COUNT_BITS-1:0] pages;
      logic                  kind;
   } entry_type;

   // Request view broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                  lookup;
      logic [PAGE_BITS-1:0]  page;
      logic [WIDE_BITS-1:0]  req_end;
      logic [COUNT_BITS-1:0] size;
      logic [PAGE_BITS-1:0]  mask;
      logic [PAGE_BITS-1:0]  zone_lo;
      logic [WIDE_BITS-1:0]  zone_hi;
      logic                  insert;
      entry_type             new_entry;
   } bcast_type;

   typedef struct packed {
      logic                  found;
      logic                  overlap;
      logic [PAGE_BITS-1:0]  value;
      logic [COUNT_BITS-1:0] pages;
      logic                  kind;
   } node_type;

   typedef struct packed {
      logic                 ok;
      logic [PAGE_BITS-1:0] top;
   } gap_type;

   // Highest aligned base of a gap whose bounds are already clamped to the arena.
   function automatic gap_type gap_check(input logic [WIDE_BITS-1:0]  lo,
                                         input logic [WIDE_BITS-1:0]  hi,
                                         input logic [COUNT_BITS-1:0] size,
                                         input logic [PAGE_BITS-1:0]  mask);
      gap_type              g;
      logic [WIDE_BITS-1:0] diff;
      logic [WIDE_BITS-1:0] top;
      logic [WIDE_BITS-1:0] bot;
      logic [WIDE_BITS-1:0] wmask;
      wmask = WIDE_BITS'(mask);
      diff  = hi - lo;
      top   = (hi - WIDE_BITS'(size)) & ~wmask;
      bot   = (lo + wmask) & ~wmask;
      g.ok  = (hi > lo) && (diff >= WIDE_BITS'(size)) && (top >= bot);
      g.top = top[PAGE_BITS-1:0];
      return g;
   endfunction

   // The upper child wins, so automatic placement takes the highest gap.
   function automatic node_type node_pick(input node_type lo, input node_type hi);
      node_type n;
      n         = hi.found ? hi : lo;
      n.found   = lo.found | hi.found;
      n.overlap = lo.overlap | hi.overlap;
      return n;
   endfunction

endpackage

FILE: rtl/aligned_range_allocator_unit.sv
// ---------------------------------------------------------------------------
// Aligned range allocator
// Top level: request sequencer, cell row, select tree and result register.
// ---------------------------------------------------------------------------
// The table of reserved ranges lives in a row of cells, one entry per cell,
// kept sorted by base page. A request passes through gap, hit and overlap
// evaluation inside every cell, the levels of the registered select tree,
// and a final step that decides, shifts the row on an insert and loads the
// result register; that step waits while a held result blocks the output.
// A new request is taken once the previous one has loaded its result,
// even if that result still waits at the output. The table needs no
// clearing after reset.
module aligned_range_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ara_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ara_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ara_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ara_pkg::COUNT_BITS-1:0]     csr_data
);

   localparam int WAIT_BITS = $clog2(ara_pkg::TREE_LEVELS + 3);
   localparam int M = ara_pkg::MAX_RANGES;

   ara_pkg::state_type                state_ff, state_in;
   logic [WAIT_BITS-1:0]              wait_ff, wait_in;
   ara_pkg::req_type                  req_ff;
   logic [ara_pkg::PAGE_BITS-1:0]     mask_ff;
   logic [ara_pkg::WIDE_BITS-1:0]     req_end_ff;
   logic [ara_pkg::USED_BITS-1:0]     used_ff, used_in;
   logic [ara_pkg::PAGE_BITS-1:0]     zone_lo_ff;
   logic [ara_pkg::COUNT_BITS-1:0]    arena_count_ff;
   logic [ara_pkg::WIDE_BITS-1:0]     zone_hi_ff, zone_hi_in;
   logic [ara_pkg::WIDE_BITS-1:0]     bot_hi_ff, bot_hi_in;
   ara_pkg::gap_type                  bot_gap_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   ara_pkg::rsp_type                  rsp_ff, rsp_in;

   ara_pkg::bcast_type                bcast;
   logic                              accept;
   logic                              fire;
   logic                              do_insert;
   logic [ara_pkg::PAGE_BITS-1:0]     place_base;
   logic [ara_pkg::WIDE_BITS-1:0]     arena_sum;
   logic [ara_pkg::WIDE_BITS-1:0]     page_w;
   logic [5:0]                        order;
   ara_pkg::node_type                 root;

   logic                              cell_valid [M];
   logic                              cell_keep  [M];
   ara_pkg::entry_type                cell_entry [M];
   ara_pkg::node_type                 cell_leaf  [M];

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ara_pkg::S_IDLE);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign fire      = (state_ff == ara_pkg::S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         ara_pkg::S_IDLE: begin
            wait_in = '0;
            if (accept) begin
               state_in = ara_pkg::S_BUSY;
            end
         end
         ara_pkg::S_BUSY: begin
            wait_in = wait_ff + WAIT_BITS'(1);
            if (wait_ff == WAIT_BITS'(ara_pkg::TREE_LEVELS + 1)) begin
               state_in = ara_pkg::S_FINISH;
            end
         end
         ara_pkg::S_FINISH: begin
            if (fire) begin
               state_in = ara_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ara_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ara_pkg::S_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   // Request capture; the alignment order saturates at the page number width.
   always_comb begin
      order = (req_data.align_order > 6'(ara_pkg::PAGE_BITS)) ?
              6'(ara_pkg::PAGE_BITS) : req_data.align_order;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff     <= req_data;
         mask_ff    <= ~({ara_pkg::PAGE_BITS{1'b1}} << order);
         req_end_ff <= ara_pkg::WIDE_BITS'(req_data.request_page) +
                       ara_pkg::WIDE_BITS'(req_data.span_pages);
      end
   end

   // Configuration registers and the clamped arena end.
   always_comb begin
      arena_sum  = ara_pkg::WIDE_BITS'(zone_lo_ff) +
                   ara_pkg::WIDE_BITS'(arena_count_ff);
      zone_hi_in = (arena_sum > ara_pkg::PAGE_SPACE) ? ara_pkg::PAGE_SPACE : arena_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_lo_ff     <= '0;
         arena_count_ff <= '0;
         zone_hi_ff     <= '0;
      end else begin
         zone_hi_ff <= zone_hi_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ara_pkg::CSR_ARENA_BASE: begin
                  zone_lo_ff <= csr_data[ara_pkg::PAGE_BITS-1:0];
               end
               ara_pkg::CSR_ARENA_COUNT: begin
                  arena_count_ff <= csr_data;
               end
               default: begin
                  arena_count_ff <= arena_count_ff;
               end
            endcase
         end
      end
   end

   // Gap between the arena base and the lowest entry, timed like the cells.
   always_comb begin
      bot_hi_in = cell_valid[0] ? ara_pkg::WIDE_BITS'(cell_entry[0].base) : zone_hi_ff;
      if (bot_hi_in > zone_hi_ff) begin
         bot_hi_in = zone_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      bot_hi_ff  <= bot_hi_in;
      bot_gap_ff <= ara_pkg::gap_check(ara_pkg::WIDE_BITS'(zone_lo_ff), bot_hi_ff,
                                       req_ff.span_pages, mask_ff);
   end

   // Final decision.
   always_comb begin
      rsp_in     = '0;
      rsp_in.status = ara_pkg::ST_BAD;
      do_insert  = 1'b0;
      place_base = req_ff.request_page;
      page_w     = ara_pkg::WIDE_BITS'(req_ff.request_page);
      case (req_ff.cmd)
         ara_pkg::CMD_LOOKUP: begin
            rsp_in.status = ara_pkg::ST_MISS;
            if (page_w >= ara_pkg::WIDE_BITS'(zone_lo_ff) && page_w < zone_hi_ff &&
                root.found) begin
               rsp_in.status      = ara_pkg::ST_OK;
               rsp_in.base_page   = root.value;
               rsp_in.found_pages = root.pages;
               rsp_in.found_kind  = root.kind;
            end
         end
         ara_pkg::CMD_RESERVE, ara_pkg::CMD_ALLOCATE: begin
            if (req_ff.span_pages == '0) begin
               rsp_in.status = ara_pkg::ST_BAD;
            end else if (used_ff == ara_pkg::USED_BITS'(M)) begin
               rsp_in.status = ara_pkg::ST_FULL;
            end else if (req_ff.request_page == '0) begin
               // Automatic placement: highest fitting gap, then the bottom gap.
               rsp_in.status = ara_pkg::ST_NOSPACE;
               if (req_ff.span_pages <= arena_count_ff) begin
                  if (root.found) begin
                     do_insert  = 1'b1;
                     place_base = root.value;
                  end else if (bot_gap_ff.ok) begin
                     do_insert  = 1'b1;
                     place_base = bot_gap_ff.top;
                  end
               end
            end else begin
               rsp_in.status = ara_pkg::ST_BAD;
               if ((req_ff.request_page & mask_ff) == '0 &&
                   req_end_ff <= ara_pkg::PAGE_SPACE && !root.overlap) begin
                  do_insert = 1'b1;
               end
            end
            if (do_insert) begin
               rsp_in.status      = ara_pkg::ST_OK;
               rsp_in.base_page   = place_base;
               rsp_in.found_pages = req_ff.span_pages;
               rsp_in.found_kind  = req_ff.cmd[0];
            end
         end
         default: begin
            rsp_in.status = ara_pkg::ST_BAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      used_in      = used_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (do_insert) begin
            used_in = used_ff + ara_pkg::USED_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Broadcast to the cell row.
   always_comb begin
      bcast.lookup          = (req_ff.cmd == ara_pkg::CMD_LOOKUP);
      bcast.page            = req_ff.request_page;
      bcast.req_end         = req_end_ff;
      bcast.size            = req_ff.span_pages;
      bcast.mask            = mask_ff;
      bcast.zone_lo         = zone_lo_ff;
      bcast.zone_hi         = zone_hi_ff;
      bcast.insert          = fire && do_insert;
      bcast.new_entry.base  = place_base;
      bcast.new_entry.pages = req_ff.span_pages;
      bcast.new_entry.kind  = req_ff.cmd[0];
   end

   genvar i;
   generate
      for (i = 0; i < M; i++) begin : g_cell
         logic                          lv, lk, rv;
         ara_pkg::entry_type            le;
         logic [ara_pkg::PAGE_BITS-1:0] rb;
         if (i == 0) begin : g_first
            assign lv = 1'b0;
            assign lk = 1'b1;
            assign le = '0;
         end else begin : g_mid
            assign lv = cell_valid[i-1];
            assign lk = cell_keep[i-1];
            assign le = cell_entry[i-1];
         end
         if (i == M - 1) begin : g_last
            assign rv = 1'b0;
            assign rb = '0;
         end else begin : g_next
            assign rv = cell_valid[i+1];
            assign rb = cell_entry[i+1].base;
         end
         ara_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .bcast       (bcast),
            .left_valid  (lv),
            .left_keep   (lk),
            .left_entry  (le),
            .right_valid (rv),
            .right_base  (rb),
            .valid       (cell_valid[i]),
            .keep        (cell_keep[i]),
            .entry       (cell_entry[i]),
            .leaf        (cell_leaf[i])
         );
      end
   endgenerate

   ara_tree u_tree (
      .clock  (clock),
      .leaves (cell_leaf),
      .root   (root)
   );

endmodule

FILE: rtl/ara_cell.sv
// ---------------------------------------------------------------------------
// Range table cell
// Holds one table entry, evaluates its gap, hit and overlap against the
// current request, and shifts up by one place on an insert below it.
// ---------------------------------------------------------------------------
module ara_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  ara_pkg::bcast_type            bcast,
   input  logic                          left_valid,
   input  logic                          left_keep,
   input  ara_pkg::entry_type            left_entry,
   input  logic                          right_valid,
   input  logic [ara_pkg::PAGE_BITS-1:0] right_base,
   output logic                          valid,
   output logic                          keep,
   output ara_pkg::entry_type            entry,
   output ara_pkg::node_type             leaf
);

   logic                          valid_ff, valid_in;
   ara_pkg::entry_type            entry_ff, entry_in;
   logic [ara_pkg::WIDE_BITS-1:0] lo_ff, lo_in;
   logic [ara_pkg::WIDE_BITS-1:0] hi_ff, hi_in;
   logic [ara_pkg::WIDE_BITS-1:0] end_ff, end_in;
   ara_pkg::node_type             leaf_ff, leaf_in;
   logic [ara_pkg::WIDE_BITS-1:0] hi_raw;
   logic [ara_pkg::WIDE_BITS-1:0] base_w;
   logic [ara_pkg::WIDE_BITS-1:0] page_w;
   ara_pkg::gap_type              gap;
   logic                          hit;
   logic                          ovl;

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign leaf  = leaf_ff;
   assign keep  = valid_ff && (entry_ff.base <= bcast.new_entry.base);

   always_comb begin
      base_w = ara_pkg::WIDE_BITS'(entry_ff.base);
      page_w = ara_pkg::WIDE_BITS'(bcast.page);

      // First stage: the gap above this entry, clamped to the arena.
      end_in = base_w + ara_pkg::WIDE_BITS'(entry_ff.pages);
      hi_raw = right_valid ? ara_pkg::WIDE_BITS'(right_base) : bcast.zone_hi;
      lo_in  = (end_in < ara_pkg::WIDE_BITS'(bcast.zone_lo)) ?
               ara_pkg::WIDE_BITS'(bcast.zone_lo) : end_in;
      hi_in  = (hi_raw > bcast.zone_hi) ? bcast.zone_hi : hi_raw;

      // Second stage: fit, lookup hit and overlap with the requested range.
      gap = ara_pkg::gap_check(lo_ff, hi_ff, bcast.size, bcast.mask);
      hit = (base_w <= page_w) && (page_w < end_ff);
      ovl = (base_w < bcast.req_end) && (page_w < end_ff);
      leaf_in.found   = valid_ff && (bcast.lookup ? hit : gap.ok);
      leaf_in.overlap = valid_ff && ovl;
      leaf_in.value   = bcast.lookup ? entry_ff.base : gap.top;
      leaf_in.pages   = entry_ff.pages;
      leaf_in.kind    = entry_ff.kind;

      // An entry above the new base moves up one place; the first one takes
      // the new entry.
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (bcast.insert && !keep) begin
         if (left_keep) begin
            valid_in = 1'b1;
            entry_in = bcast.new_entry;
         end else begin
            valid_in = left_valid;
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      end_ff   <= end_in;
      leaf_ff  <= leaf_in;
   end

endmodule

FILE: rtl/ara_tree.sv
// ---------------------------------------------------------------------------
// Registered select tree
// Picks the highest cell that reports a find and merges the overlap flags,
// one register level per tree level.
// ---------------------------------------------------------------------------
module ara_tree (
   input  logic              clock,
   input  ara_pkg::node_type leaves [ara_pkg::MAX_RANGES],
   output ara_pkg::node_type root
);

   localparam int N = ara_pkg::TREE_LEAVES;

   ara_pkg::node_type node_w  [1:2*N-1];
   ara_pkg::node_type node_ff [1:N-1];

   genvar i, k;
   generate
      for (i = 0; i < N; i++) begin : g_leaf
         if (i < ara_pkg::MAX_RANGES) begin : g_used
            assign node_w[N+i] = leaves[i];
         end else begin : g_pad
            assign node_w[N+i] = '0;
         end
      end
      for (k = 1; k < N; k++) begin : g_node
         always_ff @(posedge clock) begin
            node_ff[k] <= ara_pkg::node_pick(node_w[2*k], node_w[2*k+1]);
         end
         assign node_w[k] = node_ff[k];
      end
   endgenerate

   assign root = node_w[1];

endmodule

FILE: tb/sv/tb_aligned_range_allocator_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Aligned range allocator testbench
// A directed table followed by random requests over several arena settings.
// Responses are checked against an in-bench table model or a row's fixed expectation.
// ---------------------------------------------------------------------------
module tb_aligned_range_allocator_unit;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         IDLE_LIMIT   = 5000;
   localparam int         HOLD_CYCLES  = 250;
   localparam logic [63:0] SPACE_PAGES = 64'd1 << ara_pkg::PAGE_BITS;

   typedef struct {
      ara_pkg::req_type item;
      bit               typed;
      ara_pkg::rsp_type want;
   } row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   ara_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   ara_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ara_pkg::CSR_INDEX_BITS-1:0] csr_index = ara_pkg::CSR_ARENA_BASE;
   logic [ara_pkg::COUNT_BITS-1:0]     csr_data = '0;

   // Model of the block's table and arena registers.
   logic [63:0] range_start [ara_pkg::MAX_RANGES];
   logic [63:0] range_size  [ara_pkg::MAX_RANGES];
   logic        range_alloc [ara_pkg::MAX_RANGES];
   int          ranges_held = 0;
   logic [63:0] arena_first = 0;
   logic [63:0] arena_pages = 0;

   ara_pkg::rsp_type pending_rsp [$];
   row_type          directed [$];
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_left = 0;
   bit               hold_request = 0;
   int               quiet_cycles = 0;

   aligned_range_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] arena_limit();
      logic [63:0] e;
      e = arena_first + arena_pages;
      return (e > SPACE_PAGES) ? SPACE_PAGES : e;
   endfunction

   // Highest aligned base inside [lo, hi) after clamping to the arena.
   function automatic bit gap_fit(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [63:0] size, input logic [63:0] mask,
                                  output logic [63:0] top);
      logic [63:0] bot;
      if (lo < arena_first) lo = arena_first;
      if (hi > arena_limit()) hi = arena_limit();
      top = 0;
      if (hi <= lo || hi - lo < size) return 0;
      top = (hi - size) & ~mask;
      bot = (lo + mask) & ~mask;
      return top >= bot;
   endfunction

   function automatic ara_pkg::rsp_type apply_request(ara_pkg::req_type r);
      ara_pkg::rsp_type o;
      logic [63:0]      page, cnt, mask, hi, base;
      int               ord, pos;
      bit               ok;
      o = '0;
      o.status = ara_pkg::ST_BAD;
      page = 64'(r.request_page);
      cnt  = 64'(r.span_pages);
      if (r.cmd == ara_pkg::CMD_LOOKUP) begin
         o.status = ara_pkg::ST_MISS;
         if (page < arena_first || page >= arena_limit()) return o;
         for (int i = 0; i < ranges_held; i++) begin
            if (range_start[i] <= page && page < range_start[i] + range_size[i]) begin
               o.status      = ara_pkg::ST_OK;
               o.base_page   = range_start[i][ara_pkg::PAGE_BITS-1:0];
               o.found_pages = range_size[i][ara_pkg::COUNT_BITS-1:0];
               o.found_kind  = range_alloc[i];
               return o;
            end
         end
         return o;
      end
      if (r.cmd == CMD_UNUSED || cnt == 0) return o;
      if (ranges_held >= ara_pkg::MAX_RANGES) begin
         o.status = ara_pkg::ST_FULL;
         return o;
      end
      ord  = (r.align_order > ara_pkg::PAGE_BITS) ? ara_pkg::PAGE_BITS : int'(r.align_order);
      mask = (64'd1 << ord) - 1;
      base = 0;
      if (page == 0) begin
         ok = 0;
         if (cnt <= arena_pages) begin
            hi = arena_limit();
            for (int i = ranges_held - 1; i >= 0 && !ok; i--) begin
               ok = gap_fit(range_start[i] + range_size[i], hi, cnt, mask, base);
               hi = range_start[i];
            end
            if (!ok) ok = gap_fit(arena_first, hi, cnt, mask, base);
         end
         if (!ok) begin
            o.status = ara_pkg::ST_NOSPACE;
            return o;
         end
      end else begin
         if ((page & mask) != 0 || page + cnt > SPACE_PAGES) return o;
         for (int i = 0; i < ranges_held; i++)
            if (range_start[i] < page + cnt && page < range_start[i] + range_size[i])
               return o;
         base = page;
      end
      // Equal bases keep arrival order: the new range goes behind them.
      pos = 0;
      while (pos < ranges_held && range_start[pos] <= base) pos++;
      for (int j = ranges_held; j > pos; j--) begin
         range_start[j] = range_start[j-1];
         range_size[j]  = range_size[j-1];
         range_alloc[j] = range_alloc[j-1];
      end
      range_start[pos] = base;
      range_size[pos]  = cnt;
      range_alloc[pos] = r.cmd[0];
      ranges_held++;
      o.status      = ara_pkg::ST_OK;
      o.base_page   = base[ara_pkg::PAGE_BITS-1:0];
      o.found_pages = cnt[ara_pkg::COUNT_BITS-1:0];
      o.found_kind  = r.cmd[0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_response();
      ara_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("unexpected response", 64'(rsp_data.status), 64'd0);
         return;
      end
      want = pending_rsp.pop_front();
      if (rsp_data.status !== want.status)
         report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
      if (rsp_data.base_page !== want.base_page)
         report_mismatch("base_page", 64'(rsp_data.base_page), 64'(want.base_page));
      if (rsp_data.found_pages !== want.found_pages)
         report_mismatch("found_pages", 64'(rsp_data.found_pages), 64'(want.found_pages));
      if (rsp_data.found_kind !== want.found_kind)
         report_mismatch("found_kind", 64'(rsp_data.found_kind), 64'(want.found_kind));
   endtask

   // Response side: checking, random stall and the long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response();
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_request(ara_pkg::req_type it, bit typed, ara_pkg::rsp_type want);
      ara_pkg::rsp_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      pred = apply_request(it);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_arena(logic [63:0] first, logic [63:0] pages);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= ara_pkg::CSR_ARENA_BASE;
      csr_data  <= ara_pkg::COUNT_BITS'(first[ara_pkg::PAGE_BITS-1:0]);
      do @(posedge clock); while (!csr_ready);
      arena_first = first & (SPACE_PAGES - 1);
      csr_index <= ara_pkg::CSR_ARENA_COUNT;
      csr_data  <= pages[ara_pkg::COUNT_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      arena_pages = pages & ((SPACE_PAGES << 1) - 1);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(logic [1:0] cmd, logic [63:0] page, logic [63:0] cnt,
                          int ord, bit typed = 0,
                          ara_pkg::status_type st = ara_pkg::ST_OK,
                          logic [63:0] base = 0, logic [63:0] pages = 0, bit kind = 0);
      row_type r;
      r.item.cmd          = cmd;
      r.item.request_page = page[ara_pkg::PAGE_BITS-1:0];
      r.item.span_pages   = cnt[ara_pkg::COUNT_BITS-1:0];
      r.item.align_order  = ara_pkg::ORDER_BITS'(ord);
      r.typed             = typed;
      r.want.status       = st;
      r.want.base_page    = base[ara_pkg::PAGE_BITS-1:0];
      r.want.found_pages  = pages[ara_pkg::COUNT_BITS-1:0];
      r.want.found_kind   = kind;
      directed.push_back(r);
   endtask

   function automatic ara_pkg::req_type random_request();
      ara_pkg::req_type r;
      int               pick, k, ord;
      logic [63:0]      wide, cnt, page;
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      r = '0;
      if (pick < 45) begin
         r.cmd = ara_pkg::CMD_LOOKUP;
         if (ranges_held > 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, ranges_held - 1);
            page = range_start[k] + (wide % range_size[k]);
         end else if ($urandom_range(0, 1)) begin
            page = arena_first + 64'($urandom_range(0, 70000));
         end else begin
            page = wide;
         end
         r.request_page = page[ara_pkg::PAGE_BITS-1:0];
         r.span_pages   = ara_pkg::COUNT_BITS'({$urandom, $urandom});
         r.align_order  = ara_pkg::ORDER_BITS'($urandom);
         return r;
      end
      r.cmd = (pick < 95) ?
              ($urandom_range(0, 1) ? ara_pkg::CMD_ALLOCATE : ara_pkg::CMD_RESERVE) :
              CMD_UNUSED;
      k = $urandom_range(0, 99);
      if (k < 80)      cnt = 64'($urandom_range(1, 64));
      else if (k < 88) cnt = 0;
      else if (k < 95) cnt = wide & ((SPACE_PAGES << 1) - 1);
      else             cnt = SPACE_PAGES;
      ord = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 63);
      k = $urandom_range(0, 9);
      if (k < 5)      page = 0;
      else if (k < 8) page = arena_first + (64'($urandom_range(0, 4096)) << ((ord > 12) ? 12 : ord));
      else            page = {$urandom, $urandom};
      r.request_page = page[ara_pkg::PAGE_BITS-1:0];
      r.span_pages   = cnt[ara_pkg::COUNT_BITS-1:0];
      r.align_order  = ara_pkg::ORDER_BITS'(ord);
      return r;
   endfunction

   initial begin
      logic [63:0]      phase_first [4];
      logic [63:0]      phase_pages [4];
      ara_pkg::rsp_type none;
      none = '0;
      phase_first = '{64'h0, 64'h8000, SPACE_PAGES - 1, 64'h100};
      phase_pages = '{SPACE_PAGES, 64'h4000, SPACE_PAGES, 64'h0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_arena(64'h1000, 64'h10000);
      add_row(ara_pkg::CMD_LOOKUP, 64'h1000, 0, 0, 1, ara_pkg::ST_MISS);
      add_row(ara_pkg::CMD_RESERVE, 0, 0, 0, 1, ara_pkg::ST_BAD);
      add_row(CMD_UNUSED, 64'h1000, 16, 0, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_RESERVE, 0, SPACE_PAGES, 0, 1, ara_pkg::ST_NOSPACE);
      add_row(ara_pkg::CMD_ALLOCATE, 0, 16, 4, 1, ara_pkg::ST_OK, 64'h10FF0, 16, 1);
      add_row(ara_pkg::CMD_RESERVE, 0, 64'h100, 8);
      add_row(ara_pkg::CMD_LOOKUP, 64'h10FF5, 0, 0);
      add_row(ara_pkg::CMD_ALLOCATE, 64'h2001, 4, 1, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_ALLOCATE, SPACE_PAGES - 1, 2, 0, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_RESERVE, 64'h2000, 64'h100, 8);
      add_row(ara_pkg::CMD_ALLOCATE, 64'h2000, 64'h10, 0, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_ALLOCATE, 64'h2040, 64'h10, 4, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_ALLOCATE, 0, 1, 63);
      add_row(ara_pkg::CMD_LOOKUP, 64'h2050, 0, 0);
      add_row(ara_pkg::CMD_LOOKUP, 64'h800, 0, 0, 1, ara_pkg::ST_MISS);
      add_row(ara_pkg::CMD_LOOKUP, 64'h11000, 0, 0, 1, ara_pkg::ST_MISS);
      add_row(ara_pkg::CMD_LOOKUP, SPACE_PAGES - 1, 0, 0, 1, ara_pkg::ST_MISS);
      add_row(ara_pkg::CMD_ALLOCATE, 64'h3000, 0, 0, 1, ara_pkg::ST_BAD);
      add_row(ara_pkg::CMD_RESERVE, 64'h5000, 64'h1F, 63);
      add_row(ara_pkg::CMD_ALLOCATE, 0, 64'h10000, 0);
      add_row(ara_pkg::CMD_ALLOCATE, 0, 64'h1000, 12);
      add_row(ara_pkg::CMD_RESERVE, 0, 64'h800, 0);
      add_row(ara_pkg::CMD_LOOKUP, 64'h1000, 0, 0);
      send_idle_pct = 27;
      recv_idle_pct = 73;
      foreach (directed[i]) send_request(directed[i].item, directed[i].typed, directed[i].want);
      req_valid <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         write_arena(phase_first[p], phase_pages[p]);
         send_idle_pct = (p == 0) ? 27 : (p == 1) ? 73 : 0;
         recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 27 : 0;
         if (p == 2) hold_request = 1;
         for (int n = 0; n < 100; n++) send_request(random_request(), 0, none);
         req_valid <= 1'b0;
      end

      wait_drained();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ara_pkg.sv
rtl/ara_cell.sv
rtl/ara_tree.sv
rtl/aligned_range_allocator_unit.sv
tb/sv/tb_aligned_range_allocator_unit.sv
